// ===== sv/heartbeat_supervisor_defines.svh =====
// Assertion macros for the heartbeat supervisor checker.
// Each macro clocks on clk and is disabled while arst_n is low.
`ifndef HEARTBEAT_SUPERVISOR_DEFINES_SVH
`define HEARTBEAT_SUPERVISOR_DEFINES_SVH

// Same-cycle implication check.
`define HBS_CHECK(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check.
`define HBS_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/hb_sup_pkg.sv =====
// Shared types and constants for the heartbeat supervisor.
// No dependencies; used by the top level and its checker.
package hb_sup_pkg;

	localparam int NODES_DEF = 8;
	localparam int NODE_CAP  = 8;

	localparam int TIME_W  = 32;
	localparam int MID_W   = 29;
	localparam int NODE_W  = 3;
	localparam int OP_W    = 2;
	localparam int KIND_W  = 3;
	localparam int CIDX_W  = 3;
	localparam int CDATA_W = 32;
	localparam int MASK_W  = 8;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 72;

	// operation codes
	localparam logic [OP_W-1:0] OP_START    = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
	localparam logic [OP_W-1:0] OP_RESPONSE = 2'd2;
	localparam logic [OP_W-1:0] OP_OWN_HB   = 2'd3;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_REQUEST  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_LATE     = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MISMATCH = 3'd2;
	localparam logic [KIND_W-1:0] KIND_VERDICT  = 3'd3;
	localparam logic [KIND_W-1:0] KIND_OWN      = 3'd4;

	// register indexes
	localparam logic [CIDX_W-1:0] REG_IS_SUP   = 3'd0;
	localparam logic [CIDX_W-1:0] REG_INTERVAL = 3'd1;
	localparam logic [CIDX_W-1:0] REG_MASK     = 3'd2;
	localparam logic [CIDX_W-1:0] REG_MSG_ID   = 3'd3;
	localparam logic [CIDX_W-1:0] REG_TIMEOUT  = 3'd4;

	localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd1000;
	localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd5000;

	// per-node record held in the node memory
	typedef struct packed {
		logic [TIME_W-1:0] exp_cnt;
		logic [TIME_W-1:0] act_cnt;
		logic [TIME_W-1:0] req_time;
		logic [TIME_W-1:0] rsp_time;
	} node_rec_t;

endpackage

// ===== sv/heartbeat_supervisor.sv =====
// Heartbeat supervisor: per-node records in a small synchronous memory,
// walked by a sequencer. Depends on hb_sup_pkg.
// Steps: in the supervisor role, start runs the dispatch walk; tick runs the dispatch
//   walk if the interval has elapsed, then the check walk and the verdict; response
//   reads and updates one entry; own heartbeat and plain-role tick send a single result.
// Throughput: one item at a time, set by the single read/modify/write port
//   of the node memory (read in one state, evaluate and write in the next). Each
//   result waits for as long as the output register stays stalled.
// Reset (arst_n low): registers to reset values, all node records read as
//   zero through per-entry valid flops, output empty.
module heartbeat_supervisor
	import hb_sup_pkg::*;
#(
	parameter int NODES = NODES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input requests
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] now_ms, [34:32] node_id
	input  logic [OP_W-1:0]      s_tuser,  // [1:0] operation
	// result requests
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // [28:0] msg_id, [31:29] target_node,
	                                       // [63:32] heartbeat_value, [64] all_good
	output logic [KIND_W-1:0]    m_tuser,  // [2:0] kind
	output logic                 m_tlast,
	// configuration writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CIDX_W-1:0]    cfg_index,
	input  logic [CDATA_W-1:0]   cfg_data
);

	// only the first NODES ids, at most eight, are ever handled
	localparam int NODE_LIM = (NODES < NODE_CAP) ? NODES : NODE_CAP;
	localparam int IDX_W    = (NODE_LIM > 1) ? $clog2(NODE_LIM) : 1;

	// sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DRD  = 4'd1;  // dispatch walk: read entry
	localparam logic [3:0] ST_DEV  = 4'd2;  // dispatch walk: update, send request
	localparam logic [3:0] ST_CRD  = 4'd3;  // check walk: read entry
	localparam logic [3:0] ST_CEV  = 4'd4;  // check walk: flag late / mismatch
	localparam logic [3:0] ST_RRD  = 4'd5;  // response: read entry
	localparam logic [3:0] ST_REV  = 4'd6;  // response: update entry
	localparam logic [3:0] ST_VERD = 4'd7;  // verdict
	localparam logic [3:0] ST_OWN  = 4'd8;  // own heartbeat

	// configuration registers
	logic              is_sup_q;
	logic [TIME_W-1:0] interval_q;
	logic [MASK_W-1:0] node_mask_q;
	logic [MID_W-1:0]  msg_id_q;
	logic [TIME_W-1:0] timeout_q;

	// control state
	logic [3:0]          state_q;
	logic [IDX_W-1:0]    idx_q;
	logic [OP_W-1:0]     op_q;
	logic [TIME_W-1:0]   now_q;
	logic                bad_q;
	logic [TIME_W-1:0]   dispatch_q;
	logic [TIME_W-1:0]   own_cnt_q;
	logic [NODE_LIM-1:0] valid_q;   // doubles as node_seen

	// node memory
	node_rec_t mem_q [NODE_LIM];
	node_rec_t rdata_q;
	node_rec_t rd_rec;
	node_rec_t wdata;
	logic      mem_we;
	logic      rd_en;

	// output register
	logic              m_valid_q;
	logic [KIND_W-1:0] m_kind_q;
	logic [MID_W-1:0]  m_mid_q;
	logic [NODE_W-1:0] m_node_q;
	logic [TIME_W-1:0] m_val_q;
	logic              m_good_q;
	logic              m_last_q;

	logic              out_free;
	logic              emit;
	logic [KIND_W-1:0] e_kind;
	logic [MID_W-1:0]  e_mid;
	logic [NODE_W-1:0] e_node;
	logic [TIME_W-1:0] e_val;
	logic              e_good;
	logic              e_last;

	logic                accept;
	logic [NODE_LIM-1:0] mask_eff;
	logic                more_after;
	logic                idx_last;
	logic                late;
	logic                mism;
	logic                flag;
	logic [TIME_W-1:0]   in_now;
	logic [NODE_W-1:0]   in_id;

	assign in_now    = s_tdata[TIME_W-1:0];
	assign in_id     = s_tdata[TIME_W+NODE_W-1:TIME_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_tready;

	assign mask_eff = node_mask_q[NODE_LIM-1:0];
	assign idx_last = (idx_q == IDX_W'(NODE_LIM - 1));

	always_comb begin
		more_after = 1'b0;
		for (int i = 0; i < NODE_LIM; i++) begin
			if (mask_eff[i] && (IDX_W'(i) > idx_q)) begin
				more_after = 1'b1;
			end
		end
	end

	// entry never written reads as the all-zero reset record
	assign rd_rec = valid_q[idx_q] ? rdata_q : '0;
	assign late   = (rd_rec.rsp_time - rd_rec.req_time) > timeout_q;
	assign mism   = (rd_rec.exp_cnt != rd_rec.act_cnt) &&
	                (rd_rec.exp_cnt != (rd_rec.act_cnt + 32'd1));
	assign flag   = late || mism;

	assign rd_en = (state_q == ST_DRD) || (state_q == ST_CRD) || (state_q == ST_RRD);

	// result generation and memory writes
	always_comb begin
		emit   = 1'b0;
		e_kind = KIND_REQUEST;
		e_mid  = '0;
		e_node = '0;
		e_val  = '0;
		e_good = 1'b0;
		e_last = 1'b0;
		mem_we = 1'b0;
		wdata  = rd_rec;
		unique case (state_q)
			ST_DEV: begin
				emit             = out_free;
				mem_we           = out_free;
				e_kind           = KIND_REQUEST;
				e_mid            = msg_id_q;
				e_node           = NODE_W'(idx_q);
				e_last           = (op_q == OP_START) && !more_after;
				wdata.exp_cnt    = rd_rec.exp_cnt + 32'd1;
				wdata.req_time   = now_q;
			end
			ST_CEV: begin
				emit   = out_free && flag;
				e_kind = late ? KIND_LATE : KIND_MISMATCH;
				e_mid  = late ? msg_id_q : '0;
				e_node = NODE_W'(idx_q);
			end
			ST_REV: begin
				mem_we         = 1'b1;
				wdata.act_cnt  = rd_rec.act_cnt + 32'd1;
				wdata.rsp_time = now_q;
			end
			ST_VERD: begin
				emit   = out_free;
				e_kind = KIND_VERDICT;
				e_good = !bad_q;
				e_last = 1'b1;
			end
			ST_OWN: begin
				emit   = out_free;
				e_kind = KIND_OWN;
				e_mid  = msg_id_q;
				e_val  = own_cnt_q;
				e_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// node memory: registered read, single write port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem_q[idx_q];
		end
		if (mem_we) begin
			mem_q[idx_q] <= wdata;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_sup_q    <= 1'b1;
			interval_q  <= INTERVAL_RST;
			node_mask_q <= '0;
			msg_id_q    <= '0;
			timeout_q   <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_IS_SUP:   is_sup_q    <= cfg_data[0];
				REG_INTERVAL: interval_q  <= cfg_data;
				REG_MASK:     node_mask_q <= cfg_data[MASK_W-1:0];
				REG_MSG_ID:   msg_id_q    <= cfg_data[MID_W-1:0];
				REG_TIMEOUT:  timeout_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			op_q       <= OP_START;
			now_q      <= '0;
			bad_q      <= 1'b0;
			dispatch_q <= '0;
			own_cnt_q  <= '0;
			valid_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q  <= s_tuser;
						now_q <= in_now;
						idx_q <= '0;
						bad_q <= !is_sup_q;
						unique case (s_tuser)
							OP_START: begin
								dispatch_q <= in_now;
								if (is_sup_q) begin
									state_q <= ST_DRD;
								end
							end
							OP_TICK: begin
								if (!is_sup_q) begin
									state_q <= ST_VERD;
								end else if ((in_now - dispatch_q) >= interval_q) begin
									// the dispatch walk never reads dispatch_q
									dispatch_q <= in_now;
									state_q    <= ST_DRD;
								end else begin
									state_q <= ST_CRD;
								end
							end
							OP_RESPONSE: begin
								if (32'(in_id) < NODE_LIM) begin
									idx_q   <= in_id[IDX_W-1:0];
									state_q <= ST_RRD;
								end
							end
							OP_OWN_HB: begin
								if (!is_sup_q) begin
									own_cnt_q <= own_cnt_q + 32'd1;
									state_q   <= ST_OWN;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DRD: begin
					if (mask_eff[idx_q]) begin
						state_q <= ST_DEV;
					end else if (!idx_last) begin
						idx_q <= idx_q + IDX_W'(1);
					end else if (op_q == OP_START) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= '0;
						state_q <= ST_CRD;
					end
				end
				ST_DEV: begin
					if (out_free) begin
						valid_q[idx_q] <= 1'b1;
						if (!idx_last) begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_DRD;
						end else if (op_q == OP_START) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= '0;
							state_q <= ST_CRD;
						end
					end
				end
				ST_CRD: begin
					if (valid_q[idx_q]) begin
						state_q <= ST_CEV;
					end else if (idx_last) begin
						state_q <= ST_VERD;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_CEV: begin
					if (!flag || out_free) begin
						if (flag) begin
							bad_q <= 1'b1;
						end
						if (idx_last) begin
							state_q <= ST_VERD;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= ST_CRD;
						end
					end
				end
				ST_RRD: begin
					state_q <= ST_REV;
				end
				ST_REV: begin
					valid_q[idx_q] <= 1'b1;
					state_q        <= ST_IDLE;
				end
				ST_VERD, ST_OWN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register: loads when empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			m_kind_q <= e_kind;
			m_mid_q  <= e_mid;
			m_node_q <= e_node;
			m_val_q  <= e_val;
			m_good_q <= e_good;
			m_last_q <= e_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {(M_TDATA_W - MID_W - NODE_W - TIME_W - 1)'(0),
	                   m_good_q, m_val_q, m_node_q, m_mid_q};

endmodule

// ===== sv/heartbeat_supervisor_checker.sv =====
// Port-level checker for the heartbeat supervisor, bound to the top level.
// Depends on hb_sup_pkg and heartbeat_supervisor_defines.svh.
`include "heartbeat_supervisor_defines.svh"

module heartbeat_supervisor_checker
	import hb_sup_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic [OP_W-1:0]      s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [KIND_W-1:0]    m_tuser,
	input logic                 m_tlast,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CIDX_W-1:0]    cfg_index,
	input logic [CDATA_W-1:0]   cfg_data
);

	// stalled result holds
	`HBS_CHECK_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
		"stalled result changed")

	// a verdict or an own heartbeat always closes its item
	`HBS_CHECK(a_closing_last, m_tvalid && (m_tuser == KIND_VERDICT || m_tuser == KIND_OWN),
		m_tlast, "verdict or own heartbeat without last")

	// mismatch and verdict carry no message id
	`HBS_CHECK(a_mid_zero, m_tvalid && (m_tuser == KIND_MISMATCH || m_tuser == KIND_VERDICT),
		m_tdata[MID_W-1:0] == '0, "message id on mismatch or verdict")

	// all_good only appears on a verdict
	`HBS_CHECK(a_good_verdict, m_tvalid && m_tdata[MID_W+NODE_W+TIME_W],
		m_tuser == KIND_VERDICT, "all_good outside a verdict")

endmodule

bind heartbeat_supervisor heartbeat_supervisor_checker u_checker (.*);

// ===== verif/tb_heartbeat_supervisor.sv =====
`timescale 1ns / 1ps
// Self-checking bench for heartbeat_supervisor: feeds timed requests on the input
// stream, forecasts every result request and checks them in order on the output stream.
// Depends on hb_sup_pkg and heartbeat_supervisor.
module tb_heartbeat_supervisor;
	import hb_sup_pkg::*;

	localparam int PERIOD_NS   = 10;
	localparam int SETTLE_CYC  = 64;      // covers the longest walk, with margin
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 51;
	localparam int MAX_SHOWN   = 10;
	localparam int TRACKED     = (NODES_DEF < NODE_CAP) ? NODES_DEF : NODE_CAP;
	localparam logic [CIDX_W-1:0] REG_SPARE = REG_TIMEOUT + 3'd1;  // first unused index

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [MID_W-1:0]  mid;
		logic [NODE_W-1:0] node;
		logic [TIME_W-1:0] value;
		logic              good;
		logic              last;
	} hb_msg_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic [OP_W-1:0]      s_tuser   = OP_START;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]    m_tuser;
	logic                 m_tlast;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CIDX_W-1:0]    cfg_index = REG_IS_SUP;
	logic [CDATA_W-1:0]   cfg_data  = '0;

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int mismatches     = 0;
	int cycles         = 0;
	int useful_items   = 0;
	logic [TIME_W-1:0] clock_ms = '0;

	// forecast copy of the registers
	logic              sup_role;
	logic [TIME_W-1:0] period_ms;
	logic [MASK_W-1:0] watch_mask;
	logic [MID_W-1:0]  beat_mid;
	logic [TIME_W-1:0] late_ms;

	// forecast copy of the node records
	logic              seen      [NODE_CAP];
	logic [TIME_W-1:0] sent_cnt  [NODE_CAP];
	logic [TIME_W-1:0] heard_cnt [NODE_CAP];
	logic [TIME_W-1:0] req_ms    [NODE_CAP];
	logic [TIME_W-1:0] rsp_ms    [NODE_CAP];
	logic [TIME_W-1:0] disp_ms;
	logic [TIME_W-1:0] own_beats;

	hb_msg_t pending_msgs[$];  // forecast messages not yet seen on the output
	hb_msg_t round_msgs[$];    // messages of the request being forecast
	hb_msg_t got_msg;
	hb_msg_t want_msg;

	heartbeat_supervisor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #(PERIOD_NS / 2) clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL heartbeat_supervisor");
			$finish;
		end
	end

	// result receiver: random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// output checker: every accepted message against the oldest forecast
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_msg = '{kind:  m_tuser,
			            mid:   m_tdata[MID_W-1:0],
			            node:  m_tdata[MID_W +: NODE_W],
			            value: m_tdata[MID_W + NODE_W +: TIME_W],
			            good:  m_tdata[MID_W + NODE_W + TIME_W],
			            last:  m_tlast};
			if (pending_msgs.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected message: kind %0d node %0d value %h",
						got_msg.kind, got_msg.node, got_msg.value);
			end else begin
				want_msg = pending_msgs.pop_front();
				if (got_msg !== want_msg) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display({"message mismatch: expected kind %0d mid %h node %0d ",
							"value %h good %b last %b, got kind %0d mid %h node %0d ",
							"value %h good %b last %b"},
							want_msg.kind, want_msg.mid, want_msg.node, want_msg.value,
							want_msg.good, want_msg.last,
							got_msg.kind, got_msg.mid, got_msg.node, got_msg.value,
							got_msg.good, got_msg.last);
				end
			end
		end
	end

	function automatic hb_msg_t make_msg(input logic [KIND_W-1:0] kind,
		input logic [MID_W-1:0] mid, input logic [NODE_W-1:0] node,
		input logic [TIME_W-1:0] value, input logic good);
		return '{kind, mid, node, value, good, 1'b0};
	endfunction

	// requests to every masked node, ascending id
	task automatic queue_request_round(input logic [TIME_W-1:0] now);
		for (int i = 0; i < TRACKED; i++) begin
			if (watch_mask[i]) begin
				round_msgs = {round_msgs,
					make_msg(KIND_REQUEST, beat_mid, NODE_W'(i), '0, 1'b0)};
				sent_cnt[i] = sent_cnt[i] + 32'd1;
				req_ms[i]   = now;
				seen[i]     = 1'b1;
			end
		end
	endtask

	task automatic predict_messages(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
		input logic [NODE_W-1:0] id);
		logic              all_ok;
		logic [TIME_W-1:0] span;
		hb_msg_t           m;
		all_ok = 1'b1;
		round_msgs.delete();
		case (op)
			OP_START: begin
				disp_ms = now;
				if (sup_role)
					queue_request_round(now);
			end
			OP_TICK: begin
				if (!sup_role) begin
					round_msgs = {round_msgs, make_msg(KIND_VERDICT, '0, '0, '0, 1'b0)};
				end else begin
					span = now - disp_ms;
					if (span >= period_ms) begin
						queue_request_round(now);
						disp_ms = now;
					end
					for (int i = 0; i < TRACKED; i++) begin
						if (seen[i]) begin
							span = rsp_ms[i] - req_ms[i];
							if (span > late_ms) begin
								round_msgs = {round_msgs, make_msg(KIND_LATE, beat_mid,
									NODE_W'(i), '0, 1'b0)};
								all_ok = 1'b0;
							end else if (sent_cnt[i] != heard_cnt[i] &&
								sent_cnt[i] != heard_cnt[i] + 32'd1) begin
								round_msgs = {round_msgs, make_msg(KIND_MISMATCH, '0,
									NODE_W'(i), '0, 1'b0)};
								all_ok = 1'b0;
							end
						end
					end
					round_msgs = {round_msgs, make_msg(KIND_VERDICT, '0, '0, '0, all_ok)};
				end
			end
			OP_RESPONSE: begin
				if (id < TRACKED) begin
					heard_cnt[id] = heard_cnt[id] + 32'd1;
					rsp_ms[id]    = now;
					seen[id]      = 1'b1;
				end
			end
			OP_OWN_HB: begin
				if (!sup_role) begin
					own_beats = own_beats + 32'd1;
					round_msgs = {round_msgs,
						make_msg(KIND_OWN, beat_mid, '0, own_beats, 1'b0)};
				end
			end
		endcase
		foreach (round_msgs[k]) begin
			m      = round_msgs[k];
			m.last = (k == round_msgs.size() - 1);
			pending_msgs = {pending_msgs, m};
		end
	endtask

	// one input request; tvalid stays up after acceptance unless the next call idles
	task automatic send_item(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
		input logic [NODE_W-1:0] id);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(S_TDATA_W - TIME_W - NODE_W){1'b0}}, id, now};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (!(op == OP_OWN_HB && sup_role))
			useful_items++;
		predict_messages(op, now, id);
	endtask

	// drop tvalid, wait out all forecast messages and any silent work
	task automatic quiesce();
		s_tvalid <= 1'b0;
		while (pending_msgs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_reg(input logic [CIDX_W-1:0] idx, input logic [CDATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_IS_SUP:   sup_role   = data[0];
			REG_INTERVAL: period_ms  = data;
			REG_MASK:     watch_mask = data[MASK_W-1:0];
			REG_MSG_ID:   beat_mid   = data[MID_W-1:0];
			REG_TIMEOUT:  late_ms    = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] pick_word(input logic [31:0] usual);
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom;
			default: return usual;
		endcase
	endfunction

	// mostly small steps, now and then a jump anywhere in the 32-bit range
	function automatic logic [TIME_W-1:0] advance_clock();
		if ($urandom_range(0, 29) == 0)
			clock_ms = $urandom;
		else
			clock_ms = clock_ms + $urandom_range(0, 250);
		return clock_ms;
	endfunction

	// reset config, nothing seen yet
	task automatic test_idle_supervisor();
		set_reg(REG_SPARE, '1);                 // unused index, must not land anywhere
		send_item(OP_TICK, 32'd0, 3'd0);        // lone good verdict, interval not elapsed
		send_item(OP_OWN_HB, 32'd0, 3'd7);      // supervisor ignores own heartbeat
		send_item(OP_START, 32'd0, 3'd0);       // empty mask: no requests
	endtask

	// all nodes requested and answered across the time wrap
	task automatic test_full_dispatch();
		quiesce();
		set_reg(REG_MASK, '1);
		set_reg(REG_MSG_ID, '1);
		send_item(OP_START, 32'hFFFF_FFF0, 3'd0);
		for (int n = 0; n < TRACKED; n++)
			send_item(OP_RESPONSE, 32'd5, NODE_W'(n));
		send_item(OP_TICK, 32'd10, 3'd0);
	endtask

	// zero timeout flags every node; zero interval adds a full request round
	task automatic test_late_nodes();
		quiesce();
		set_reg(REG_TIMEOUT, '0);
		send_item(OP_TICK, 32'd20, 3'd0);
		quiesce();
		set_reg(REG_INTERVAL, '0);
		send_item(OP_TICK, 32'd30, 3'd0);
	endtask

	// counts: equal, one behind (fine), ahead and two behind (both flagged)
	task automatic test_count_mismatch();
		quiesce();
		set_reg(REG_TIMEOUT, '1);
		set_reg(REG_INTERVAL, INTERVAL_RST);
		set_reg(REG_MASK, 32'h0000_0004);
		send_item(OP_RESPONSE, 32'd40, 3'd0);
		send_item(OP_RESPONSE, 32'd41, 3'd1);
		send_item(OP_RESPONSE, 32'd42, 3'd1);
		send_item(OP_START, 32'd50, 3'd0);
		send_item(OP_TICK, 32'd60, 3'd0);
	endtask

	// largest interval: one ms short, then exactly due
	task automatic test_interval_edges();
		quiesce();
		set_reg(REG_INTERVAL, '1);
		send_item(OP_TICK, disp_ms + 32'hFFFF_FFFE, 3'd0);
		send_item(OP_TICK, disp_ms + 32'hFFFF_FFFF, 3'd0);
	endtask

	task automatic test_plain_role();
		quiesce();
		set_reg(REG_IS_SUP, '0);
		send_item(OP_START, 32'd100, 3'd0);     // no requests from a plain node
		send_item(OP_TICK, 32'd200, 3'd0);      // bad verdict only
		send_item(OP_OWN_HB, 32'd300, 3'd0);
		send_item(OP_OWN_HB, 32'd301, 3'd5);
		send_item(OP_RESPONSE, 32'd400, 3'd7);  // still recorded
		quiesce();
		set_reg(REG_IS_SUP, 32'd1);
	endtask

	// random config, then mostly well-formed rounds: optional start, responses
	// from most masked nodes in rotated order, optional own heartbeat, tick; the rest is noise
	task automatic run_random_phase(input int mode);
		logic [CDATA_W-1:0] word;
		int                 rot;
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
			default: begin send_idle_pct = 37; recv_stall_pct = 37; end
		endcase
		quiesce();
		word    = $urandom;
		word[0] = ($urandom_range(0, 3) != 0);
		set_reg(REG_IS_SUP, word);
		set_reg(REG_INTERVAL, pick_word($urandom_range(1, 400)));
		set_reg(REG_MASK, pick_word($urandom));
		set_reg(REG_MSG_ID, pick_word($urandom));
		set_reg(REG_TIMEOUT, pick_word($urandom_range(0, 600)));
		if ($urandom_range(0, 1) == 0)
			set_reg(CIDX_W'(REG_SPARE + $urandom_range(0, 2)), $urandom);
		useful_items = 0;
		while (useful_items < PHASE_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				rot = $urandom_range(0, TRACKED - 1);
				if ($urandom_range(0, 2) == 0)
					send_item(OP_START, advance_clock(), NODE_W'($urandom));
				for (int n = 0; n < TRACKED; n++)
					if (watch_mask[(n + rot) % TRACKED] && $urandom_range(0, 6) != 0)
						send_item(OP_RESPONSE, advance_clock(), NODE_W'((n + rot) % TRACKED));
				if ($urandom_range(0, 3) == 0)
					send_item(OP_OWN_HB, advance_clock(), NODE_W'($urandom));
				send_item(OP_TICK, advance_clock(), NODE_W'($urandom));
			end else begin
				send_item(OP_W'($urandom), advance_clock(), NODE_W'($urandom));
			end
		end
	endtask

	initial begin
		sup_role   = 1'b1;
		period_ms  = INTERVAL_RST;
		watch_mask = '0;
		beat_mid   = '0;
		late_ms    = TIMEOUT_RST;
		for (int i = 0; i < NODE_CAP; i++) begin
			seen[i]      = 1'b0;
			sent_cnt[i]  = '0;
			heard_cnt[i] = '0;
			req_ms[i]    = '0;
			rsp_ms[i]    = '0;
		end
		disp_ms   = '0;
		own_beats = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_supervisor();
		test_full_dispatch();
		test_late_nodes();
		test_count_mismatch();
		test_interval_edges();
		test_plain_role();
		for (int p = 0; p < PHASES; p++)
			run_random_phase(p % 4);

		quiesce();
		if (mismatches == 0) begin
			$display("PASS heartbeat_supervisor");
		end else begin
			$display("FAIL heartbeat_supervisor");
		end
		$finish;
	end

endmodule
